/* hdl/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int ID_W       = 37;
    localparam int SCORE_W    = 14;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 56;
    localparam int DEPTH_DEF  = 64;

    localparam logic [SCORE_W-1:0] THRESH_RESET = 14'd200;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef struct packed {
        logic               urgent;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

/* hdl/tcpq_cell.sv */
// ----------------------------------------------------------------------------
// tcpq_cell
// One slot of the queue chain: holds, loads the new entry, or takes a neighbor.
// ----------------------------------------------------------------------------
module tcpq_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 7
) (
    input  logic                aclk,
    input  tcpq_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]       pos,
    input  tcpq_pkg::entry_t    new_entry,
    input  tcpq_pkg::entry_t    left_entry,
    input  tcpq_pkg::entry_t    right_entry,
    output tcpq_pkg::entry_t    entry
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);

    tcpq_pkg::entry_t entry_reg;
    tcpq_pkg::entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.pop) begin
            entry_next = right_entry;
        end else if (ctrl.insert) begin
            if (IDX == pos) begin
                entry_next = new_entry;
            end else if (IDX > pos) begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hdl/tcpq_chain.sv */
// ----------------------------------------------------------------------------
// tcpq_chain
// Row of queue cells; slot zero is the head.
// ----------------------------------------------------------------------------
module tcpq_chain #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEF,
    parameter int PW    = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  tcpq_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]        pos,
    input  tcpq_pkg::entry_t     new_entry,
    output tcpq_pkg::entry_t     head
);

    tcpq_pkg::entry_t slot [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tcpq_pkg::entry_t left_w;
        tcpq_pkg::entry_t right_w;

        if (i == 0) begin : g_first
            assign left_w = new_entry;
        end else begin : g_mid_l
            assign left_w = slot[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = new_entry;
        end else begin : g_mid_r
            assign right_w = slot[i+1];
        end

        tcpq_cell #(
            .INDEX (i),
            .PW    (PW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .pos         (pos),
            .new_entry   (new_entry),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (slot[i])
        );
    end

    assign head = slot[0];

endmodule

/* hdl/two_class_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Bounded queue with an urgent class ahead of a normal class.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tuser kind, tdata id and score
// m_       out  m_tvalid/m_tready    tuser status, tdata id, score, urgent
// cfg_     in   cfg_valid/cfg_ready  cfg_data urgent threshold
//
// Each accepted request yields one registered result beat in the next cycle.
// A new request is taken whenever the result register is empty or being read.
// The shift chain moves every cell at once on an insert or a pop.
// Reset empties the queue and sets the threshold to 200; no clearing pass.
// A stalled result beat holds the input side until it is taken.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcpq_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_id, entry_score
    input  logic                             s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tcpq_pkg::M_TDATA_W-1:0]   m_tdata,  // out_id, out_score, out_urgent
    output logic [1:0]                       m_tuser,  // status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcpq_pkg::SCORE_W-1:0]     cfg_data
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] FULL_COUNT = PW'(DEPTH);
    localparam int PAY_W = tcpq_pkg::ID_W + tcpq_pkg::SCORE_W + 1;

    logic [tcpq_pkg::SCORE_W-1:0] thresh_reg;
    logic [PW-1:0]                occ_reg, occ_next;
    logic [PW-1:0]                ucnt_reg, ucnt_next;
    logic                         m_valid_reg;
    tcpq_pkg::status_t            status_reg, status_next;
    tcpq_pkg::entry_t             res_reg, res_next;

    tcpq_pkg::entry_t     new_entry;
    tcpq_pkg::entry_t     head;
    tcpq_pkg::cell_ctrl_t ctrl;
    logic [PW-1:0]        pos;
    logic                 accept;
    logic                 is_enq;
    logic                 full;
    logic                 empty;

    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign is_enq    = (s_tuser == tcpq_pkg::KIND_ENQ);
    assign full      = (occ_reg == FULL_COUNT);
    assign empty     = (occ_reg == '0);

    assign new_entry.id     = s_tdata[tcpq_pkg::ID_W-1:0];
    assign new_entry.score  = s_tdata[tcpq_pkg::ID_W +: tcpq_pkg::SCORE_W];
    assign new_entry.urgent = (new_entry.score < thresh_reg);

    assign pos         = new_entry.urgent ? ucnt_reg : occ_reg;
    assign ctrl.insert = accept && is_enq && !full;
    assign ctrl.pop    = accept && !is_enq && !empty;

    tcpq_chain #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .pos       (pos),
        .new_entry (new_entry),
        .head      (head)
    );

    always_comb begin
        occ_next    = occ_reg;
        ucnt_next   = ucnt_reg;
        status_next = status_reg;
        res_next    = res_reg;
        if (ctrl.insert) begin
            occ_next = occ_reg + PW'(1);
            if (new_entry.urgent) begin
                ucnt_next = ucnt_reg + PW'(1);
            end
        end else if (ctrl.pop) begin
            occ_next = occ_reg - PW'(1);
            if (head.urgent) begin
                ucnt_next = ucnt_reg - PW'(1);
            end
        end
        if (accept) begin
            if (is_enq) begin
                status_next     = full ? tcpq_pkg::ST_DROPPED : tcpq_pkg::ST_ENQUEUED;
                res_next        = new_entry;
                res_next.id     = '0;
            end else if (empty) begin
                status_next = tcpq_pkg::ST_EMPTY;
                res_next    = '0;
            end else begin
                status_next = tcpq_pkg::ST_SERVED;
                res_next    = head;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= tcpq_pkg::THRESH_RESET;
            occ_reg     <= '0;
            ucnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            occ_reg  <= occ_next;
            ucnt_reg <= ucnt_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(tcpq_pkg::M_TDATA_W - PAY_W){1'b0}},
                       res_reg.urgent, res_reg.score, res_reg.id};

    a_ucnt_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg <= occ_reg)
        else $error("urgent count exceeds occupancy");

    a_head_urgent : assert property (@(posedge aclk) disable iff (!aresetn)
        (ucnt_reg != '0) |-> head.urgent)
        else $error("head is not urgent while urgent entries wait");

    a_drop_full : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_enq && full) |=>
            (m_tuser == tcpq_pkg::ST_DROPPED) && (occ_reg == FULL_COUNT))
        else $error("enqueue into a full queue not dropped");

    a_serve_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_enq && !empty) |=> (occ_reg == $past(occ_reg) - PW'(1)))
        else $error("served beat did not lower occupancy");

endmodule

/* tb/sv/two_class_priority_queue_top_test.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_top_test
// Self-checking test of the two-class priority queue.
//
// Requests are sent as beats on the s_ stream and each result beat on the
// m_ stream is compared field by field against a predictor that keeps its
// own copy of the queue and threshold. A short directed part covers empty
// and full queues, class ordering, threshold boundaries and field extremes.
// Random phases then run with several thresholds, moving the fill level up
// and down; both sides idle at random except in one steady phase.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEF;

    typedef logic [tcpq_pkg::ID_W-1:0]    id_t;
    typedef logic [tcpq_pkg::SCORE_W-1:0] score_t;

    localparam id_t    ID_MAX_DEC     = 37'd99999999999;
    localparam id_t    ID_ALL_ONES    = {tcpq_pkg::ID_W{1'b1}};
    localparam score_t SCORE_TOP      = 14'd10000;
    localparam score_t SCORE_ALL_ONES = {tcpq_pkg::SCORE_W{1'b1}};

    typedef struct packed {
        tcpq_pkg::status_t status;
        id_t               id;
        score_t            score;
        logic              urgent;
    } queue_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [tcpq_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [tcpq_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [1:0]                       m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    score_t                           cfg_data;

    tcpq_pkg::entry_t        waiting_entries [QUEUE_DEPTH];
    int                      waiting_count;
    score_t                  urgent_limit;
    queue_result_t           pending_results [$];
    int                      error_count;
    bit                      steady_run;

    two_class_priority_queue_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic queue_result_t predict_request(tcpq_pkg::kind_t kind, id_t id,
                                                       score_t score);
        queue_result_t r;
        logic urg;
        int pos;
        r = '0;
        if (kind == tcpq_pkg::KIND_ENQ) begin
            urg = (score < urgent_limit);
            r.score = score;
            r.urgent = urg;
            if (waiting_count >= QUEUE_DEPTH) begin
                r.status = tcpq_pkg::ST_DROPPED;
            end else begin
                pos = waiting_count;
                if (urg) begin
                    pos = 0;
                    while (pos < waiting_count && waiting_entries[pos].urgent) pos++;
                end
                for (int j = waiting_count; j > pos; j--)
                    waiting_entries[j] = waiting_entries[j-1];
                waiting_entries[pos] = '{urgent: urg, score: score, id: id};
                waiting_count++;
                r.status = tcpq_pkg::ST_ENQUEUED;
            end
        end else if (waiting_count == 0) begin
            r.status = tcpq_pkg::ST_EMPTY;
        end else begin
            r.status = tcpq_pkg::ST_SERVED;
            r.id = waiting_entries[0].id;
            r.score = waiting_entries[0].score;
            r.urgent = waiting_entries[0].urgent;
            for (int j = 1; j < waiting_count; j++)
                waiting_entries[j-1] = waiting_entries[j];
            waiting_count--;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : result_check
        queue_result_t got_r;
        queue_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got_r.status = tcpq_pkg::status_t'(m_tuser);
            got_r.id = m_tdata[tcpq_pkg::ID_W-1:0];
            got_r.score = m_tdata[tcpq_pkg::ID_W +: tcpq_pkg::SCORE_W];
            got_r.urgent = m_tdata[tcpq_pkg::ID_W+tcpq_pkg::SCORE_W];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected, status %0d",
                                          m_tuser));
            end else begin
                exp_r = pending_results.pop_front();
                if (got_r.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got_r.status, exp_r.status));
                if (got_r.id !== exp_r.id)
                    report_mismatch($sformatf("out_id %0d, expected %0d",
                                              got_r.id, exp_r.id));
                if (got_r.score !== exp_r.score)
                    report_mismatch($sformatf("out_score %0d, expected %0d",
                                              got_r.score, exp_r.score));
                if (got_r.urgent !== exp_r.urgent)
                    report_mismatch($sformatf("out_urgent %0b, expected %0b",
                                              got_r.urgent, exp_r.urgent));
            end
        end
        m_tready <= steady_run ? 1'b1 : ($urandom_range(99) >= 12);
    end

    task automatic send_request(tcpq_pkg::kind_t kind, id_t id, score_t score);
        while (!steady_run && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(tcpq_pkg::S_TDATA_W-tcpq_pkg::ID_W-tcpq_pkg::SCORE_W){1'b0}},
                    score, id};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_request(kind, id, score));
    endtask

    task automatic enqueue(id_t id, score_t score);
        send_request(tcpq_pkg::KIND_ENQ, id, score);
    endtask

    task automatic dequeue();
        send_request(tcpq_pkg::KIND_DEQ, random_id(), random_score());
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(score_t value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        urgent_limit = value;
    endtask

    function automatic id_t random_id();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(19) == 0)
            return ($urandom_range(1) == 0) ? ID_MAX_DEC : '0;
        return raw[tcpq_pkg::ID_W-1:0];
    endfunction

    function automatic score_t random_score();
        int v;
        case ($urandom_range(9))
            6, 7: begin
                v = int'(urgent_limit) + int'($urandom_range(4)) - 2;
                if (v < 0) v = 0;
                if (v > int'(SCORE_ALL_ONES)) v = int'(SCORE_ALL_ONES);
            end
            8: v = $urandom_range(SCORE_ALL_ONES);
            9: v = ($urandom_range(1) == 0) ? 0 : int'(SCORE_TOP);
            default: v = $urandom_range(SCORE_TOP);
        endcase
        return v[tcpq_pkg::SCORE_W-1:0];
    endfunction

    // Reset threshold: empty queue, class ordering, boundary scores, id extremes.
    task automatic test_directed_ordering();
        dequeue();
        enqueue('0, '0);
        enqueue(ID_MAX_DEC, SCORE_TOP);
        enqueue(ID_ALL_ONES, SCORE_ALL_ONES);
        enqueue(37'd1, tcpq_pkg::THRESH_RESET - 14'd1);
        enqueue(37'd2, tcpq_pkg::THRESH_RESET);
        enqueue(37'd3, tcpq_pkg::THRESH_RESET + 14'd1);
        repeat (7) dequeue();
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        enqueue(37'd10, '0);
        enqueue(37'd11, SCORE_ALL_ONES);
        dequeue();
        dequeue();
        wait_idle();
        write_threshold(SCORE_ALL_ONES);
        enqueue(37'd20, SCORE_ALL_ONES);
        enqueue(37'd21, SCORE_ALL_ONES - 14'd1);
        enqueue(37'd22, '0);
        repeat (3) dequeue();
        wait_idle();
    endtask

    task automatic test_fill_and_drain();
        write_threshold(14'd5000);
        repeat (QUEUE_DEPTH + 4) enqueue(random_id(), random_score());
        repeat (QUEUE_DEPTH + 4) dequeue();
        wait_idle();
    endtask

    task automatic test_random_phase(score_t threshold, int count, bit no_idle);
        int enq_pct;
        write_threshold(threshold);
        steady_run = no_idle;
        enq_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    default: enq_pct = 80;
                endcase
            end
            if ($urandom_range(99) < enq_pct)
                enqueue(random_id(), random_score());
            else
                dequeue();
        end
        wait_idle();
        steady_run = 1'b0;
    endtask

    initial begin
        error_count = 0;
        steady_run = 1'b0;
        waiting_count = 0;
        urgent_limit = tcpq_pkg::THRESH_RESET;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= tcpq_pkg::KIND_ENQ;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ordering();
        test_threshold_extremes();
        test_fill_and_drain();
        test_random_phase('0, 160, 1'b0);
        test_random_phase(SCORE_ALL_ONES, 160, 1'b0);
        test_random_phase(SCORE_TOP, 170, 1'b1);
        test_random_phase(score_t'($urandom_range(SCORE_TOP)), 160, 1'b0);
        test_random_phase(score_t'($urandom_range(SCORE_TOP)), 160, 1'b0);
        test_random_phase(14'd1, 150, 1'b0);

        wait_idle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
